[sv/gbe_pkg.sv]
// Package: widths, types and saturating helpers for the gravity Euler step.
`default_nettype none
package gbe_pkg;

  localparam int W = 32;          // word width
  localparam int F = 16;          // fraction bits
  localparam int SQ_STAGES  = W;  // one root bit per stage
  localparam int DIV_STAGES = W;  // one quotient bit per stage
  localparam int LATENCY = 4 + SQ_STAGES + 2 + DIV_STAGES + 5;

  localparam logic CFG_GRAV = 1'b0;
  localparam logic CFG_STEP = 1'b1;

  localparam logic [W-1:0] GRAV_RST = W'(437388);
  localparam logic [W-1:0] STEP_RST = W'(6554);

  typedef logic signed [W-1:0] word_t;
  typedef logic [W-1:0]        umag_t;
  typedef logic [W-2:0]        ureg_t;
  typedef logic [2*W-3:0]      gm_t;
  typedef logic [2*W-1:0]      dbl_t;

  typedef struct packed {
    logic  degen;
    word_t px;
    word_t py;
    word_t vx;
    word_t vy;
    logic  dxn;
    logic  dyn;
    umag_t adx;
    umag_t ady;
    gm_t   gm;
  } side_t;

  typedef struct packed {
    side_t       sd;
    umag_t       r;
    dbl_t        rr;
    logic        cap;
    dbl_t        arem;
    umag_t       anum;
    umag_t       aq;
    umag_t       xrem;
    umag_t       yrem;
    logic [F:0]  xnum;
    logic [F:0]  ynum;
    logic [F:0]  xq;
    logic [F:0]  yq;
  } div_t;

  function automatic umag_t mag(input word_t v);
    umag_t u;
    u = umag_t'(v);
    return v[W-1] ? (~u + umag_t'(1)) : u;
  endfunction

  // signed result of magnitude m (m <= 2^W) with sign neg, saturated
  function automatic word_t sat_sgn(input logic neg, input logic [W:0] m);
    logic [W:0] lim;
    word_t      r;
    lim = (W+1)'(1) << (W-1);
    if (!neg) begin
      r = (m >= lim) ? word_t'({1'b0, {(W-1){1'b1}}}) : word_t'(m[W-1:0]);
    end else begin
      r = (m > lim) ? word_t'({1'b1, {(W-1){1'b0}}}) : word_t'(~m[W-1:0] + umag_t'(1));
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic [W:0] s;
    word_t      r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? word_t'({1'b1, {(W-1){1'b0}}}) : word_t'({1'b0, {(W-1){1'b1}}});
    end else begin
      r = word_t'(s[W-1:0]);
    end
    return r;
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic [W:0] s;
    word_t      r;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? word_t'({1'b1, {(W-1){1'b0}}}) : word_t'({1'b0, {(W-1){1'b1}}});
    end else begin
      r = word_t'(s[W-1:0]);
    end
    return r;
  endfunction

  // scale product by 2^-F, cap magnitude at 2^W, apply sign
  function automatic word_t mulq_fin(input logic neg, input logic [2*W-2:0] prod);
    logic [2*W-2:0] sh;
    logic [W:0]     m;
    sh = prod >> F;
    m  = (sh > ((2*W-1)'(1) << W)) ? ((W+1)'(1) << W) : sh[W:0];
    return sat_sgn(neg, m);
  endfunction

endpackage
`default_nettype wire

[sv/gbe_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module gbe_isqrt (
  input  wire logic                   clk,
  input  wire logic [2*gbe_pkg::W-1:0] rad_i,
  output logic      [gbe_pkg::W-1:0]   root_o
);
  import gbe_pkg::*;

  logic [W:0]     rem_r  [SQ_STAGES];
  logic [W-1:0]   root_r [SQ_STAGES];
  logic [2*W-1:0] rad_r  [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
    logic [W:0]     rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rad_p;
    logic [W+1:0]   rem2;
    logic [W+1:0]   trial;
    logic           ge;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end
    assign rem2  = {rem_p[W-1:0], rad_p[2*W-1:2*W-2]};
    assign trial = {root_p, 2'b01};
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (W+1)'(rem2 - trial) : rem2[W:0];
      root_r[k] <= {root_p[W-2:0], ge};
      rad_r[k]  <= rad_p << 2;
    end
  end

  assign root_o = root_r[SQ_STAGES-1];

endmodule
`default_nettype wire

[sv/two_body_gravity_euler_step.sv]
// Top level: pipelined semi-implicit Euler step of a body under gravity.
// Throughput: one beat per cycle; busy is always low, as no stage ever stalls.
// The depth is set by the 32-stage root and the 32-stage quotient pipelines.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// G and dt; beats in flight are dropped.
`default_nettype none
module two_body_gravity_euler_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire gbe_pkg::ureg_t       in_self_mass,
  input  wire gbe_pkg::word_t       in_self_pos_x,
  input  wire gbe_pkg::word_t       in_self_pos_y,
  input  wire gbe_pkg::word_t       in_self_vel_x,
  input  wire gbe_pkg::word_t       in_self_vel_y,
  input  wire gbe_pkg::ureg_t       in_other_mass,
  input  wire gbe_pkg::word_t       in_other_pos_x,
  input  wire gbe_pkg::word_t       in_other_pos_y,
  output logic                      out_valid,
  output gbe_pkg::word_t            out_next_pos_x,
  output gbe_pkg::word_t            out_next_pos_y,
  output gbe_pkg::word_t            out_next_vel_x,
  output gbe_pkg::word_t            out_next_vel_y,
  output logic                      out_degenerate,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire gbe_pkg::ureg_t       cfg_wdata
);
  import gbe_pkg::*;

  // ---- configuration ----
  ureg_t grav_r, step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RST[W-2:0];
      step_r <= STEP_RST[W-2:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAV: grav_r <= cfg_wdata;
        CFG_STEP: step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- valid bits: pipeline never stalls, so a plain shift line ----
  logic [LATENCY-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], start};
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LATENCY-1];

  // ---- stage 0: capture the beat ----
  ureg_t m1_r, m2_r;
  word_t spx_r, spy_r, svx_r, svy_r, opx_r, opy_r;

  always_ff @(posedge clk) begin
    m1_r  <= in_self_mass;
    m2_r  <= in_other_mass;
    spx_r <= in_self_pos_x;
    spy_r <= in_self_pos_y;
    svx_r <= in_self_vel_x;
    svy_r <= in_self_vel_y;
    opx_r <= in_other_pos_x;
    opy_r <= in_other_pos_y;
  end

  // ---- stage 1: separation (saturated), magnitudes, G*m2 ----
  side_t s1_nxt, s1_r;
  word_t dx, dy;

  always_comb begin
    dx = sat_sub(opx_r, spx_r);
    dy = sat_sub(opy_r, spy_r);
    s1_nxt.degen = (m1_r == '0) || (dx == '0 && dy == '0);
    s1_nxt.px    = spx_r;
    s1_nxt.py    = spy_r;
    s1_nxt.vx    = svx_r;
    s1_nxt.vy    = svy_r;
    s1_nxt.dxn   = dx[W-1];
    s1_nxt.dyn   = dy[W-1];
    s1_nxt.adx   = mag(dx);
    s1_nxt.ady   = mag(dy);
    s1_nxt.gm    = grav_r * m2_r;
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // ---- stage 2: squares ----
  side_t s2_r;
  dbl_t  sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    s2_r  <= s1_r;
    sqx_r <= s1_r.adx * s1_r.adx;
    sqy_r <= s1_r.ady * s1_r.ady;
  end

  // ---- stage 3: radicand (each square at most 2^62, no carry out) ----
  side_t s3_r;
  dbl_t  rad_r;

  always_ff @(posedge clk) begin
    s3_r  <= s2_r;
    rad_r <= sqx_r + sqy_r;
  end

  // ---- root pipeline, sideband delayed alongside ----
  umag_t root;
  side_t sd_r [SQ_STAGES];

  gbe_isqrt u_sqrt (
    .clk    (clk),
    .rad_i  (rad_r),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    sd_r[0] <= s3_r;
    for (int i = 1; i < SQ_STAGES; i++) begin
      sd_r[i] <= sd_r[i-1];
    end
  end

  // ---- stage 4: r and r^2 ----
  side_t s4_r;
  umag_t r4_r;
  dbl_t  rr4_r;

  always_ff @(posedge clk) begin
    s4_r  <= sd_r[SQ_STAGES-1];
    r4_r  <= root;
    rr4_r <= root * root;
  end

  // ---- divider set-up: cap test for G*m2/r^2, first remainders ----
  div_t dv_r [DIV_STAGES+1];
  logic [2*W-3+F:0] anum_full;
  logic [W+F-1:0]   xnum_full, ynum_full;

  always_comb begin
    anum_full = {s4_r.gm, F'(0)};
    xnum_full = {s4_r.adx, F'(0)};
    ynum_full = {s4_r.ady, F'(0)};
  end

  always_ff @(posedge clk) begin
    dv_r[0].sd   <= s4_r;
    dv_r[0].r    <= r4_r;
    dv_r[0].rr   <= rr4_r;
    // quotient of 2^W or more saturates to 2^W
    dv_r[0].cap  <= dbl_t'(anum_full >> W) >= rr4_r;
    dv_r[0].arem <= dbl_t'(anum_full >> W);
    dv_r[0].anum <= anum_full[W-1:0];
    dv_r[0].aq   <= '0;
    dv_r[0].xrem <= umag_t'(xnum_full >> (F+1));
    dv_r[0].yrem <= umag_t'(ynum_full >> (F+1));
    dv_r[0].xnum <= xnum_full[F:0];
    dv_r[0].ynum <= ynum_full[F:0];
    dv_r[0].xq   <= '0;
    dv_r[0].yq   <= '0;
  end

  // ---- restoring quotient stages: amag over 32, unit vector over F+1 ----
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t         p, n;
    logic [2*W:0] arem2;
    logic [W:0]   xrem2, yrem2;
    logic         age, xge, yge;
    assign p     = dv_r[k];
    assign arem2 = {p.arem, p.anum[W-1]};
    assign age   = arem2 >= {1'b0, p.rr};
    assign xrem2 = {p.xrem, p.xnum[F]};
    assign yrem2 = {p.yrem, p.ynum[F]};
    assign xge   = xrem2 >= {1'b0, p.r};
    assign yge   = yrem2 >= {1'b0, p.r};
    always_comb begin
      n      = p;
      n.arem = age ? dbl_t'(arem2 - {1'b0, p.rr}) : arem2[2*W-1:0];
      n.aq   = {p.aq[W-2:0], age};
      n.anum = p.anum << 1;
      if (k <= F) begin
        n.xrem = xge ? umag_t'(xrem2 - {1'b0, p.r}) : xrem2[W-1:0];
        n.yrem = yge ? umag_t'(yrem2 - {1'b0, p.r}) : yrem2[W-1:0];
        n.xq   = {p.xq[F-1:0], xge};
        n.yq   = {p.yq[F-1:0], yge};
        n.xnum = p.xnum << 1;
        n.ynum = p.ynum << 1;
      end
    end
    always_ff @(posedge clk) begin
      dv_r[k+1] <= n;
    end
  end

  // ---- stage 6: acceleration components ----
  div_t               dq;
  logic [W:0]         amag;
  logic [W+F+1:0]     axp, ayp;
  logic [W+F+1:0]     axs, ays;
  logic [W:0]         axm, aym;
  side_t              s6_r;
  word_t              ax_r, ay_r;

  always_comb begin
    dq   = dv_r[DIV_STAGES];
    amag = dq.cap ? ((W+1)'(1) << W) : {1'b0, dq.aq};
    axp  = amag * dq.xq;
    ayp  = amag * dq.yq;
    axs  = axp >> F;
    ays  = ayp >> F;
    axm  = (axs > ((W+F+2)'(1) << W)) ? ((W+1)'(1) << W) : axs[W:0];
    aym  = (ays > ((W+F+2)'(1) << W)) ? ((W+1)'(1) << W) : ays[W:0];
  end

  always_ff @(posedge clk) begin
    s6_r <= dq.sd;
    ax_r <= sat_sgn(dq.sd.dxn, axm);
    ay_r <= sat_sgn(dq.sd.dyn, aym);
  end

  // ---- stage 7: a*dt ----
  side_t          s7_r;
  logic [2*W-2:0] pax_r, pay_r;
  logic           axn_r, ayn_r;

  always_ff @(posedge clk) begin
    s7_r  <= s6_r;
    pax_r <= mag(ax_r) * step_r;
    pay_r <= mag(ay_r) * step_r;
    axn_r <= ax_r[W-1];
    ayn_r <= ay_r[W-1];
  end

  // ---- stage 8: velocity first; degenerate keeps it ----
  side_t s8_nxt, s8_r;

  always_comb begin
    s8_nxt = s7_r;
    if (!s7_r.degen) begin
      s8_nxt.vx = sat_add(s7_r.vx, mulq_fin(axn_r, pax_r));
      s8_nxt.vy = sat_add(s7_r.vy, mulq_fin(ayn_r, pay_r));
    end
  end

  always_ff @(posedge clk) begin
    s8_r <= s8_nxt;
  end

  // ---- stage 9: v'*dt ----
  side_t          s9_r;
  logic [2*W-2:0] pvx_r, pvy_r;

  always_ff @(posedge clk) begin
    s9_r  <= s8_r;
    pvx_r <= mag(s8_r.vx) * step_r;
    pvy_r <= mag(s8_r.vy) * step_r;
  end

  // ---- stage 10: position from the new velocity, output register ----
  always_ff @(posedge clk) begin
    out_next_vel_x <= s9_r.vx;
    out_next_vel_y <= s9_r.vy;
    out_degenerate <= s9_r.degen;
    if (s9_r.degen) begin
      out_next_pos_x <= s9_r.px;
      out_next_pos_y <= s9_r.py;
    end else begin
      out_next_pos_x <= sat_add(s9_r.px, mulq_fin(s9_r.vx[W-1], pvx_r));
      out_next_pos_y <= sat_add(s9_r.py, mulq_fin(s9_r.vy[W-1], pvy_r));
    end
  end

endmodule
`default_nettype wire

[sv/gbe_checker.sv]
// Port checker for the gravity Euler step, bound to the top level.
`default_nettype none
module gbe_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire gbe_pkg::ureg_t in_self_mass,
  input wire gbe_pkg::word_t in_self_pos_x,
  input wire logic           out_valid,
  input wire logic           out_degenerate,
  input wire gbe_pkg::word_t out_next_pos_x
);
  import gbe_pkg::*;

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result beat without an accepted beat");

  a_degen_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> out_next_pos_x == $past(in_self_pos_x, LATENCY))
    else $error("degenerate beat altered position");

  a_zero_mass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_self_mass == '0, LATENCY)) |-> out_degenerate)
    else $error("zero own mass not flagged");

endmodule

bind two_body_gravity_euler_step gbe_checker u_chk (.*);
`default_nettype wire
